// ----- hw/rtl/pad_pkg.sv -----
// Package for the phase-angle dimmer: event codes, register indexes and
// register reset values. No dependencies.
package pad_pkg;

  // Event carried in tuser of each input word
  typedef enum logic [1:0] {
    ActTimerTick = 2'd0,
    ActMsTick    = 2'd1,
    ActZeroCross = 2'd2,
    ActSetLevel  = 2'd3
  } action_e;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 3;
  typedef enum logic [CfgAddrW-1:0] {
    CfgRampMsPerStep = 3'd0,
    CfgPeriodTop     = 3'd1,
    CfgPulseEnd      = 3'd2,
    CfgPreloadBase   = 3'd3,
    CfgPreloadSlope  = 3'd4
  } cfg_addr_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SlopeW   = 8;

  // Register reset values
  localparam logic [15:0]       RampMsPerStepRst = 16'd1;
  localparam logic [15:0]       PeriodTopRst     = 16'd40000;
  localparam logic [15:0]       PulseEndRst      = 16'd10;
  localparam logic [15:0]       PreloadBaseRst   = 16'd21894;
  localparam logic [SlopeW-1:0] PreloadSlopeRst  = 8'd71;

endpackage

// ----- hw/rtl/phase_angle_dimmer_with_ramp.sv -----
// Phase-angle mains dimmer with level ramp, top level.
// Depends on pad_pkg; checked by pad_check (bound from its own file).
//
// Result: the word for an accepted input is registered in the output register, or in the skid register if stalled.
// Throughput: one word per cycle; all event logic (one 8xLEVEL multiply-add and
//   a few compares) sits between the event input and a two-entry output stage
//   (output register plus skid register), so input is stalled only when both hold words.
// Reset: asynchronous, active low; registers take their documented reset values,
//   the phase counter is stopped until the first zero crossing.
module phase_angle_dimmer_with_ramp #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned LEVEL_WIDTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [pad_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [pad_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // event stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] new_level
  input  logic [1:0]                      s_axis_tuser,  // [1:0] action
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata   // [0] gate, [8:1] current_level
);
  import pad_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int unsigned ProdW = SlopeW + LEVEL_WIDTH;
  localparam int unsigned PreW = ((ProdW > 16) ? ProdW : 16) + 1;

  // configuration registers
  logic [15:0]       ramp_ms_q, period_top_q, pulse_end_q, preload_base_q;
  logic [SlopeW-1:0] preload_slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_ms_q       <= RampMsPerStepRst;
      period_top_q    <= PeriodTopRst;
      pulse_end_q     <= PulseEndRst;
      preload_base_q  <= PreloadBaseRst;
      preload_slope_q <= PreloadSlopeRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_e'(cfg_addr_i))
        CfgRampMsPerStep: ramp_ms_q       <= cfg_wdata_i;
        CfgPeriodTop:     period_top_q    <= cfg_wdata_i;
        CfgPulseEnd:      pulse_end_q     <= cfg_wdata_i;
        CfgPreloadBase:   preload_base_q  <= cfg_wdata_i;
        CfgPreloadSlope:  preload_slope_q <= cfg_wdata_i[SlopeW-1:0];
        default: ;
      endcase
    end
  end

  // dimmer state
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   running_q, running_d;
  logic                   gate_q, gate_d;
  logic                   blocked_q, blocked_d;
  logic [LEVEL_WIDTH-1:0] level_q, level_d;
  logic [LEVEL_WIDTH-1:0] target_q, target_d;
  logic [15:0]            ms_q, ms_d;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // zero-crossing preload, saturated at top
  logic [PreW-1:0] preload;
  logic [15:0]     preload_sat;
  assign preload = PreW'(preload_base_q) + PreW'(preload_slope_q) * PreW'(level_q);
  assign preload_sat = (preload > PreW'(period_top_q)) ? period_top_q : preload[15:0];

  // millisecond ramp helpers
  logic [15:0] ms_inc;
  logic [15:0] interval;
  assign ms_inc   = (ms_q != 16'hFFFF) ? ms_q + 16'd1 : ms_q;
  assign interval = (ramp_ms_q != 16'd0) ? ramp_ms_q : 16'd1;

  // event next-state logic
  always_comb begin
    count_d   = count_q;
    running_d = running_q;
    gate_d    = gate_q;
    blocked_d = blocked_q;
    level_d   = level_q;
    target_d  = target_q;
    ms_d      = ms_q;
    case (action_e'(s_axis_tuser))
      ActTimerTick: begin
        if (running_q) begin
          if (count_q == COUNT_WIDTH'(period_top_q) || count_q == '1) begin
            count_d = '0;
            gate_d  = 1'b1;
          end else begin
            if (!blocked_q && CmpW'(count_q) == CmpW'(pulse_end_q)) begin
              gate_d = 1'b0;
            end
            count_d = count_q + COUNT_WIDTH'(1);
          end
          blocked_d = 1'b0;
        end
      end
      ActMsTick: begin
        ms_d = ms_inc;
        if (level_q != target_q && ms_inc >= interval) begin
          ms_d    = '0;
          level_d = (target_q > level_q) ? level_q + LEVEL_WIDTH'(1)
                                         : level_q - LEVEL_WIDTH'(1);
        end
      end
      ActZeroCross: begin
        count_d   = COUNT_WIDTH'(preload_sat);
        running_d = 1'b1;
        blocked_d = 1'b1;
      end
      ActSetLevel: begin
        target_d = LEVEL_WIDTH'(s_axis_tdata);
        ms_d     = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      running_q <= 1'b0;
      gate_q    <= 1'b0;
      blocked_q <= 1'b0;
      level_q   <= '0;
      target_q  <= '0;
      ms_q      <= '0;
    end else if (in_acc) begin
      count_q   <= count_d;
      running_q <= running_d;
      gate_q    <= gate_d;
      blocked_q <= blocked_d;
      level_q   <= level_d;
      target_q  <= target_d;
      ms_q      <= ms_d;
    end
  end

  // result word
  logic [15:0] res_word;
  assign res_word = {7'd0, 8'(level_d), gate_d};

  // output register plus skid register
  logic        out_vld_q, skid_vld_q;
  logic [15:0] out_data_q, skid_data_q;
  logic        out_free;

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_vld_q ? skid_data_q : res_word;
    end else if (in_acc) begin
      skid_data_q <= res_word;
    end
  end

endmodule

// ----- hw/rtl/pad_check.sv -----
// Port-level checks for the phase-angle dimmer, bound to the top level.
// Depends on phase_angle_dimmer_with_ramp port list only.
module pad_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // input stalls only while a result word is waiting
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // every accepted event yields a pending result word next cycle
  a_acc_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed");

endmodule

bind phase_angle_dimmer_with_ramp pad_check u_pad_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
